// ===== design/lrs_pkg.sv =====
// Shared constants, types and the digit function of the radix sorter.
package lrs_pkg;

   localparam int MAX_KEYS   = 16384;
   localparam int DIGIT_BITS = 8;
   localparam int PASSES     = 3;
   localparam int KEY_BITS   = 24;

   localparam int ADDR_W = $clog2(MAX_KEYS);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;

   localparam logic [PASS_W-1:0] LAST_PASS  = PASS_W'(PASSES - 1);
   localparam logic              SORTED_SEL = 1'(PASSES % 2);
   localparam logic [CNT_W-1:0]  MAX_COUNT  = CNT_W'(MAX_KEYS);

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [PASS_W-1:0]     pass_type;

   typedef struct packed {
      logic load;
      logic start;
      logic bkt_clr;
      logic bkt_inc;
      logic bkt_upd;
      logic pre_wr;
      logic sel_digit;
      logic latch_key;
      logic idx_clr;
      logic idx_inc;
      logic sum_clr;
      logic dst_wr;
      logic pass_inc;
      logic sort_done;
      logic rd_load;
   } cmd_type;

   typedef struct packed {
      logic idx_done;
      logic bkt_last;
      logic pass_last;
      logic out_free;
   } sts_type;

   function automatic digit_type digit_of(key_type key, pass_type pass);
      int      shift;
      key_type shifted;
      shift = int'(pass) * DIGIT_BITS;
      if (shift >= KEY_BITS) begin
         shifted = '0;
      end else begin
         shifted = key >> shift;
      end
      return shifted[DIGIT_BITS-1:0];
   endfunction

endpackage

// ===== design/lsd_radix_sort_24bit.sv =====
// Loads are taken while idle; the request that carries the final mark also starts the sort.
// The sort makes one pass per 8-bit digit, lowest first: each pass clears the 256 bucket counts,
// counts the keys per digit, forms prefix sums over the buckets and moves every key to the other
// buffer at the address that its bucket count holds.
// An accepted read loads its response into the output register once that register is free.
// Synchronous reset empties the key set and the output register; buffer contents stay undefined.
module lsd_radix_sort_24bit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   input  lrs_pkg::key_type req_key_in,
   input  logic             req_final_key,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lrs_pkg::key_type rsp_key_out,
   output logic             rsp_last_out,
   output logic             rsp_empty_res
);
   import lrs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lrs_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_final_key (req_final_key),
      .sts           (sts),
      .cmd           (cmd)
   );

   lrs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_key_in    (req_key_in),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_key_out   (rsp_key_out),
      .rsp_last_out  (rsp_last_out),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

// ===== design/lrs_datapath.sv =====
// Datapath of the radix sorter: key buffers, bucket counts, counters and output register.
module lrs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  lrs_pkg::cmd_type cmd,
   output lrs_pkg::sts_type sts,
   input  lrs_pkg::key_type req_key_in,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output lrs_pkg::key_type rsp_key_out,
   output logic             rsp_last_out,
   output logic             rsp_empty_res
);
   import lrs_pkg::*;

   key_type   key_store_mem  [MAX_KEYS];
   key_type   swap_store_mem [MAX_KEYS];
   count_type bucket_mem     [1 << DIGIT_BITS];

   key_type   rd0_ff, rd1_ff;
   count_type bkt_rd_ff;
   digit_type digit_ff, digit_in;
   key_type   key_ff, key_in;

   count_type key_count_ff, key_count_in;
   count_type read_index_ff, read_index_in;
   count_type idx_ff, idx_in;
   count_type sum_ff, sum_in;
   digit_type bkt_ff, bkt_in;
   pass_type  pass_ff, pass_in;
   logic      ready_ff, ready_in;

   logic      rsp_valid_ff, rsp_valid_in;
   key_type   rsp_key_ff, rsp_key_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_empty_ff, rsp_empty_in;

   key_type   src_key, sorted_key;
   digit_type digit_now, bkt_raddr, bkt_waddr;
   count_type bkt_wdata;
   logic      bkt_we;
   addr_type  buf_raddr, buf0_waddr, dst_addr;
   key_type   buf0_wdata;
   logic      buf0_we, buf1_we, load_we;
   logic      empty_now;

   always_comb begin
      src_key    = pass_ff[0] ? rd1_ff : rd0_ff;
      sorted_key = SORTED_SEL ? rd1_ff : rd0_ff;
      digit_now  = digit_of(src_key, pass_ff);
      bkt_raddr  = cmd.sel_digit ? digit_now : bkt_ff;
      bkt_waddr  = cmd.bkt_upd ? digit_ff : bkt_ff;
      bkt_we     = cmd.bkt_clr | cmd.bkt_upd | cmd.pre_wr;
      if (cmd.bkt_upd) begin
         bkt_wdata = bkt_rd_ff + count_type'(1);
      end else if (cmd.pre_wr) begin
         bkt_wdata = sum_ff;
      end else begin
         bkt_wdata = '0;
      end
      buf_raddr  = ready_ff ? read_index_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
      dst_addr   = bkt_rd_ff[ADDR_W-1:0];
      load_we    = cmd.load & (ready_ff | (key_count_ff < MAX_COUNT));
      buf0_we    = load_we | (cmd.dst_wr & pass_ff[0]);
      buf1_we    = cmd.dst_wr & ~pass_ff[0];
      if (cmd.load) begin
         buf0_waddr = ready_ff ? '0 : key_count_ff[ADDR_W-1:0];
         buf0_wdata = req_key_in;
      end else begin
         buf0_waddr = dst_addr;
         buf0_wdata = key_ff;
      end
      empty_now  = ~(ready_ff & (read_index_ff < key_count_ff));
   end

   always_ff @(posedge clock) begin
      if (buf0_we) begin
         key_store_mem[buf0_waddr] <= buf0_wdata;
      end
      rd0_ff <= key_store_mem[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (buf1_we) begin
         swap_store_mem[dst_addr] <= key_ff;
      end
      rd1_ff <= swap_store_mem[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bucket_mem[bkt_waddr] <= bkt_wdata;
      end
      bkt_rd_ff <= bucket_mem[bkt_raddr];
   end

   always_comb begin
      key_count_in  = key_count_ff;
      read_index_in = read_index_ff;
      ready_in      = ready_ff;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      bkt_in        = bkt_ff;
      pass_in       = pass_ff;
      digit_in      = digit_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (cmd.load) begin
         ready_in = 1'b0;
         if (ready_ff) begin
            key_count_in  = count_type'(1);
            read_index_in = '0;
         end else if (key_count_ff < MAX_COUNT) begin
            key_count_in = key_count_ff + count_type'(1);
         end
      end
      if (cmd.start) begin
         pass_in = '0;
         bkt_in  = '0;
      end
      if (cmd.bkt_inc) begin
         bkt_in = bkt_ff + digit_type'(1);
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + count_type'(1);
      end
      if (cmd.sum_clr) begin
         sum_in = '0;
      end else if (cmd.pre_wr) begin
         sum_in = sum_ff + bkt_rd_ff;
      end
      if (cmd.latch_key) begin
         digit_in = digit_now;
         key_in   = src_key;
      end
      if (cmd.pass_inc) begin
         pass_in = pass_ff + pass_type'(1);
      end
      if (cmd.sort_done) begin
         ready_in      = 1'b1;
         read_index_in = '0;
      end
      if (cmd.rd_load) begin
         rsp_valid_in = 1'b1;
         rsp_empty_in = empty_now;
         if (empty_now) begin
            rsp_key_in  = '0;
            rsp_last_in = 1'b0;
         end else begin
            rsp_key_in    = sorted_key;
            rsp_last_in   = (read_index_ff + count_type'(1)) == key_count_ff;
            read_index_in = read_index_ff + count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff  <= '0;
         read_index_ff <= '0;
         ready_ff      <= 1'b0;
         idx_ff        <= '0;
         sum_ff        <= '0;
         bkt_ff        <= '0;
         pass_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         key_count_ff  <= key_count_in;
         read_index_ff <= read_index_in;
         ready_ff      <= ready_in;
         idx_ff        <= idx_in;
         sum_ff        <= sum_in;
         bkt_ff        <= bkt_in;
         pass_ff       <= pass_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff     <= digit_in;
      key_ff       <= key_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   always_comb begin
      sts.idx_done  = (idx_ff == key_count_ff);
      sts.bkt_last  = &bkt_ff;
      sts.pass_last = (pass_ff == LAST_PASS);
      sts.out_free  = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule

// ===== design/lrs_controller.sv =====
// Controller state machine that sequences loading, the sort passes and reads.
module lrs_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   input  logic             req_final_key,
   input  lrs_pkg::sts_type sts,
   output lrs_pkg::cmd_type cmd
);
   import lrs_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_CLR      = 11'b000_0000_0010,
      S_CNT_PREP = 11'b000_0000_0100,
      S_CNT_A    = 11'b000_0000_1000,
      S_CNT_B    = 11'b000_0001_0000,
      S_PRE_A    = 11'b000_0010_0000,
      S_PRE_B    = 11'b000_0100_0000,
      S_DST_PREP = 11'b000_1000_0000,
      S_DST_A    = 11'b001_0000_0000,
      S_DST_B    = 11'b010_0000_0000,
      S_RD_OUT   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_READ) begin
                  state_in = S_RD_OUT;
               end else begin
                  cmd.load = 1'b1;
                  if (req_final_key) begin
                     cmd.start = 1'b1;
                     state_in  = S_CLR;
                  end
               end
            end
         end
         S_CLR: begin
            cmd.bkt_clr = 1'b1;
            cmd.bkt_inc = 1'b1;
            if (sts.bkt_last) begin
               cmd.idx_clr = 1'b1;
               cmd.sum_clr = 1'b1;
               state_in    = S_CNT_PREP;
            end
         end
         S_CNT_PREP: begin
            state_in = sts.idx_done ? S_PRE_A : S_CNT_A;
         end
         S_CNT_A: begin
            cmd.sel_digit = 1'b1;
            cmd.latch_key = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_in      = S_CNT_B;
         end
         S_CNT_B: begin
            cmd.bkt_upd = 1'b1;
            state_in    = sts.idx_done ? S_PRE_A : S_CNT_A;
         end
         S_PRE_A: begin
            state_in = S_PRE_B;
         end
         S_PRE_B: begin
            cmd.pre_wr  = 1'b1;
            cmd.bkt_inc = 1'b1;
            if (sts.bkt_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_DST_PREP;
            end else begin
               state_in = S_PRE_A;
            end
         end
         S_DST_PREP: begin
            if (!sts.idx_done) begin
               state_in = S_DST_A;
            end else if (sts.pass_last) begin
               cmd.sort_done = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.pass_inc = 1'b1;
               state_in     = S_CLR;
            end
         end
         S_DST_A: begin
            cmd.sel_digit = 1'b1;
            cmd.latch_key = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_in      = S_DST_B;
         end
         S_DST_B: begin
            cmd.bkt_upd = 1'b1;
            cmd.dst_wr  = 1'b1;
            if (!sts.idx_done) begin
               state_in = S_DST_A;
            end else if (sts.pass_last) begin
               cmd.sort_done = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.pass_inc = 1'b1;
               state_in     = S_CLR;
            end
         end
         S_RD_OUT: begin
            if (sts.out_free) begin
               cmd.rd_load = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
